// ===== rtl/sshm_pkg.sv =====
// Shared types, codes and helpers for the sample health monitor.
package sshm_pkg;

   localparam int VALUE_W     = 20;
   localparam int TOL_W       = 10;
   localparam int SAT_W       = 19;
   localparam int THRESH_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SAT_W;
   localparam int RUN_W       = 16;
   localparam int MASK_OUT_W  = 4;

   typedef enum logic [1:0] {
      REQ_CHANNEL = 2'd0,
      REQ_STALE   = 2'd1,
      REQ_RESET   = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      QUAL_WARMING     = 3'd0,
      QUAL_VALID       = 3'd1,
      QUAL_SATURATED   = 3'd2,
      QUAL_STUCK_CONST = 3'd3,
      QUAL_STUCK_SAT   = 3'd4,
      QUAL_STALE       = 3'd5
   } quality_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOLERANCE     = 3'd0,
      CSR_SAT_LEVEL     = 3'd1,
      CSR_CHANGES       = 3'd2,
      CSR_SAT_STUCK     = 3'd3,
      CSR_CONST_STUCK   = 3'd4
   } csr_index_type;

   localparam logic [TOL_W-1:0]    TOL_RESET         = 10'd1;
   localparam logic [SAT_W-1:0]    SAT_LEVEL_RESET   = 19'd262136;
   localparam logic [THRESH_W-1:0] CHANGES_RESET     = 16'd2;
   localparam logic [THRESH_W-1:0] SAT_STUCK_RESET   = 16'd16;
   localparam logic [THRESH_W-1:0] CONST_STUCK_RESET = 16'd32;
   localparam logic [RUN_W-1:0]    RUN_MAX           = 16'hFFFF;

   // One channel row as kept in the sample stores.
   typedef struct packed {
      logic signed [VALUE_W-1:0] delta;
      logic signed [VALUE_W-1:0] raw;
      logic signed [VALUE_W-1:0] baseline;
   } sample_type;

   // True when |a - b| exceeds the tolerance (quarter units).
   function automatic logic value_differs(input logic signed [VALUE_W-1:0] a,
                                          input logic signed [VALUE_W-1:0] b,
                                          input logic [TOL_W-1:0] tol);
      logic signed [VALUE_W:0] diff;
      logic [VALUE_W:0]        mag;
      diff = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
      mag  = diff[VALUE_W] ? (~diff + 1'b1) : diff;
      return mag > {{(VALUE_W + 1 - TOL_W){1'b0}}, tol};
   endfunction

endpackage

// ===== rtl/sshm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sshm_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                         write_data,
   input  logic                                     read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents on a same-address collision.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem[read_address];
      end
   end

endmodule

// ===== rtl/sar_sample_health_monitor.sv =====
// Top level of the sample health monitor: request pipeline, sample stores, grading.
// Usage:
//   A sample is sent as one request per channel, channel 0 first, last channel
//   last (req_type channel values). The last channel request yields one
//   response with the quality grade, the identical run, the saturation mask
//   and two status bits. A stale request yields one response with the stale
//   grade; a reset request clears the monitor state and yields nothing.
//   Configuration registers are written through the csr_ port while idle.
// Timing:
//   One request per cycle is taken while req_stall is low. The previous-sample
//   row is read from the bank RAMs at the accept edge; compare, count update and
//   grading load the output register when the grading stage advances. Previous
//   and pending values live in two banks of CHANNELS rows; a per-channel bank
//   select flips instead of copying a whole sample, and a write at the accept
//   edge is forwarded to the read it overtakes.
// Reset and stall:
//   reset clears control state and loads the register defaults; the sample
//   RAMs are not cleared. While rsp_stall holds a response, the block keeps
//   taking requests until the next response-producing request reaches the
//   grading stage, then raises req_stall until the output register frees.
module sar_sample_health_monitor
   import sshm_pkg::*;
#(
   parameter int CHANNELS   = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic [1:0]                  req_channel_index,
   input  logic signed [VALUE_W-1:0]   req_delta_value,
   input  logic signed [VALUE_W-1:0]   req_raw_value,
   input  logic signed [VALUE_W-1:0]   req_baseline_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_quality,
   output logic [RUN_W-1:0]            rsp_identical_run,
   output logic [MASK_OUT_W-1:0]       rsp_saturated_mask,
   output logic                        rsp_data_usable,
   output logic                        rsp_data_changing,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W   = $bits(sample_type);
   localparam logic [CH_BITS-1:0]    LAST_CH   = CH_BITS'(CHANNELS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration
   logic [TOL_W-1:0]    tol_ff;
   logic [SAT_W-1:0]    sat_level_ff;
   logic [THRESH_W-1:0] changes_ff;
   logic [THRESH_W-1:0] sat_stuck_ff;
   logic [THRESH_W-1:0] const_stuck_ff;

   // grading stage
   logic                s1_valid_ff;
   logic [1:0]          s1_type_ff;
   logic [1:0]          s1_ch_ff;
   sample_type          s1_row_ff;

   // forwarding of the write made at the edge a request was taken
   logic                fwd_valid_ff;
   logic                fwd_bank_ff;
   logic [CH_BITS-1:0]  fwd_ch_ff;
   sample_type          fwd_row_ff;

   // monitor state
   logic [CHANNELS-1:0]   sel_ff, sel_in;
   logic [CHANNELS-1:0]   dirty_ff, dirty_in;
   logic                  has_prev_ff, has_prev_in;
   logic                  differs_ff, differs_in;
   logic [CHANNELS-1:0]   mask_acc_ff, mask_acc_in;
   logic [CHANNELS-1:0]   mask_reg_ff, mask_reg_in;
   logic [COUNT_BITS-1:0] ident_ff, ident_in;
   logic [COUNT_BITS-1:0] change_ff, change_in;
   quality_type           grade_ff, grade_in;

   // output register
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_quality_ff;
   logic [RUN_W-1:0]      rsp_run_ff;
   logic [MASK_OUT_W-1:0] rsp_mask_ff;
   logic                  rsp_usable_ff;
   logic                  rsp_changing_ff;

   logic                accept;
   logic [CH_BITS-1:0]  req_ci;
   logic                req_ch_ok;
   logic                s1_hold;
   logic                advance;
   logic [CH_BITS-1:0]  ci;
   logic                ch_ok;
   logic                is_chan;
   logic                is_last;
   logic                commit;
   logic                copy;
   logic                emit;
   logic                prev_bank;
   logic                fwd_hit;
   sample_type          rd_row0, rd_row1, prev_row;
   logic                wr_en;
   logic                wr_bank;
   logic                diff_any;
   logic                differs_now;
   logic [CHANNELS-1:0] ch_bit;
   logic [CHANNELS-1:0] mask_now;
   logic                sat_hit;
   logic [31:0]         ident_ext;
   logic [31:0]         mask_ext;

   assign req_ci    = CH_BITS'(32'(req_channel_index));
   assign req_ch_ok = 32'(req_channel_index) < CHANNELS;
   assign accept    = req_valid && !req_stall;

   assign ci      = CH_BITS'(32'(s1_ch_ff));
   assign ch_ok   = 32'(s1_ch_ff) < CHANNELS;
   assign is_chan = (s1_type_ff == REQ_CHANNEL) && ch_ok;
   assign is_last = (ci == LAST_CH);
   assign emit    = s1_valid_ff && ((is_chan && is_last) || (s1_type_ff == REQ_STALE));
   assign s1_hold = emit && rsp_valid_ff && rsp_stall;
   assign advance = s1_valid_ff && !s1_hold;
   assign req_stall = s1_hold;

   // previous sample row: selected bank, or the write that just landed there
   assign prev_bank = sel_ff[ci];
   assign fwd_hit   = fwd_valid_ff && (fwd_ch_ff == ci) && (fwd_bank_ff == prev_bank);
   assign prev_row  = fwd_hit ? fwd_row_ff : (prev_bank ? rd_row1 : rd_row0);

   assign wr_en   = advance && is_chan;
   assign wr_bank = ~prev_bank;

   sshm_ram #(.WIDTH(ROW_W), .DEPTH(CHANNELS)) u_bank0 (
      .clock         (clock),
      .write_enable  (wr_en && !wr_bank),
      .write_address (ci),
      .write_data    (s1_row_ff),
      .read_enable   (accept && req_ch_ok),
      .read_address  (req_ci),
      .read_data     (rd_row0)
   );

   sshm_ram #(.WIDTH(ROW_W), .DEPTH(CHANNELS)) u_bank1 (
      .clock         (clock),
      .write_enable  (wr_en && wr_bank),
      .write_address (ci),
      .write_data    (s1_row_ff),
      .read_enable   (accept && req_ch_ok),
      .read_address  (req_ci),
      .read_data     (rd_row1)
   );

   assign diff_any = value_differs(prev_row.delta, s1_row_ff.delta, tol_ff)
                   | value_differs(prev_row.raw, s1_row_ff.raw, tol_ff)
                   | value_differs(prev_row.baseline, s1_row_ff.baseline, tol_ff);
   assign differs_now = differs_ff | diff_any;
   assign ch_bit   = CHANNELS'(1) << ci;
   assign sat_hit  = $signed(s1_row_ff.raw) >= $signed({1'b0, sat_level_ff});
   assign mask_now = mask_acc_ff | (sat_hit ? ch_bit : '0);
   assign commit   = is_chan && is_last;
   assign copy     = commit && (!has_prev_ff || differs_now);

   always_comb begin
      sel_in      = sel_ff;
      dirty_in    = dirty_ff;
      has_prev_in = has_prev_ff;
      differs_in  = differs_ff;
      mask_acc_in = mask_acc_ff;
      mask_reg_in = mask_reg_ff;
      ident_in    = ident_ff;
      change_in   = change_ff;
      grade_in    = grade_ff;
      if (s1_type_ff == REQ_STALE) begin
         grade_in = QUAL_STALE;
      end else if (s1_type_ff == REQ_RESET) begin
         sel_in      = '0;
         dirty_in    = '0;
         has_prev_in = 1'b0;
         differs_in  = 1'b0;
         mask_acc_in = '0;
         mask_reg_in = '0;
         ident_in    = '0;
         change_in   = '0;
         grade_in    = QUAL_WARMING;
      end else if (is_chan) begin
         dirty_in    = dirty_ff | ch_bit;
         differs_in  = differs_now;
         mask_acc_in = mask_now;
         if (commit) begin
            mask_reg_in = mask_now;
            differs_in  = 1'b0;
            mask_acc_in = '0;
            if (copy) begin
               // pending bank becomes previous for every channel written since
               sel_in   = sel_ff ^ (dirty_ff | ch_bit);
               dirty_in = '0;
            end
            if (!has_prev_ff) begin
               has_prev_in = 1'b1;
               grade_in    = QUAL_WARMING;
            end else begin
               if (!differs_now) begin
                  if (ident_ff != COUNT_MAX) ident_in = ident_ff + 1'b1;
               end else begin
                  ident_in = '0;
                  if (change_ff != COUNT_MAX) change_in = change_ff + 1'b1;
               end
               if (mask_now != '0) begin
                  grade_in = (32'(ident_in) >= 32'(sat_stuck_ff)) ? QUAL_STUCK_SAT
                                                                 : QUAL_SATURATED;
               end else if (32'(ident_in) >= 32'(const_stuck_ff)) begin
                  grade_in = QUAL_STUCK_CONST;
               end else if (32'(change_in) >= 32'(changes_ff)) begin
                  grade_in = QUAL_VALID;
               end else begin
                  grade_in = QUAL_WARMING;
               end
            end
         end
      end
   end

   assign ident_ext = 32'(ident_in);
   assign mask_ext  = 32'(mask_reg_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff         <= TOL_RESET;
         sat_level_ff   <= SAT_LEVEL_RESET;
         changes_ff     <= CHANGES_RESET;
         sat_stuck_ff   <= SAT_STUCK_RESET;
         const_stuck_ff <= CONST_STUCK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TOLERANCE:   tol_ff         <= csr_write_data[TOL_W-1:0];
            CSR_SAT_LEVEL:   sat_level_ff   <= csr_write_data[SAT_W-1:0];
            CSR_CHANGES:     changes_ff     <= csr_write_data[THRESH_W-1:0];
            CSR_SAT_STUCK:   sat_stuck_ff   <= csr_write_data[THRESH_W-1:0];
            CSR_CONST_STUCK: const_stuck_ff <= csr_write_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= wr_en;
         end else if (advance) begin
            s1_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff         <= req_type;
         s1_ch_ff           <= req_channel_index;
         s1_row_ff.delta    <= req_delta_value;
         s1_row_ff.raw      <= req_raw_value;
         s1_row_ff.baseline <= req_baseline_value;
         fwd_bank_ff        <= wr_bank;
         fwd_ch_ff          <= ci;
         fwd_row_ff         <= s1_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= '0;
         dirty_ff    <= '0;
         has_prev_ff <= 1'b0;
         differs_ff  <= 1'b0;
         mask_acc_ff <= '0;
         mask_reg_ff <= '0;
         ident_ff    <= '0;
         change_ff   <= '0;
         grade_ff    <= QUAL_WARMING;
      end else if (advance) begin
         sel_ff      <= sel_in;
         dirty_ff    <= dirty_in;
         has_prev_ff <= has_prev_in;
         differs_ff  <= differs_in;
         mask_acc_ff <= mask_acc_in;
         mask_reg_ff <= mask_reg_in;
         ident_ff    <= ident_in;
         change_ff   <= change_in;
         grade_ff    <= grade_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_quality_ff  <= grade_in;
         rsp_run_ff      <= (ident_ext > 32'(RUN_MAX)) ? RUN_MAX : ident_ext[RUN_W-1:0];
         rsp_mask_ff     <= mask_ext[MASK_OUT_W-1:0];
         rsp_usable_ff   <= (grade_in == QUAL_VALID);
         rsp_changing_ff <= (change_in != '0) && (grade_in != QUAL_STUCK_CONST)
                            && (grade_in != QUAL_STUCK_SAT) && (grade_in != QUAL_STALE);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quality        = rsp_quality_ff;
   assign rsp_identical_run  = rsp_run_ff;
   assign rsp_saturated_mask = rsp_mask_ff;
   assign rsp_data_usable    = rsp_usable_ff;
   assign rsp_data_changing  = rsp_changing_ff;

   a_usable_matches_grade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data_usable == (rsp_quality == QUAL_VALID)))
      else $error("usable flag disagrees with quality");

   a_changing_not_stuck: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_changing) |->
         (rsp_quality != QUAL_STUCK_CONST && rsp_quality != QUAL_STUCK_SAT
          && rsp_quality != QUAL_STALE))
      else $error("changing flag set on a stuck or stale grade");

   a_copy_clears_dirty: assert property (@(posedge clock) disable iff (reset)
      (advance && copy) |=> (dirty_ff == '0))
      else $error("dirty bits survive a sample copy");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost before grading stage");

   a_hold_keeps_response: assert property (@(posedge clock) disable iff (reset)
      s1_hold |=> (rsp_valid_ff && s1_valid_ff))
      else $error("held request dropped while response waits");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for sar_sample_health_monitor: directed and random request streams, grade prediction.
`timescale 1ns / 1ps

module tb_top
   import sshm_pkg::*;
();

   localparam int NUM_CH        = 4;
   localparam int COUNT_W       = 16;
   localparam int LAST_CH       = NUM_CH - 1;
   localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
   localparam int VALUE_MAX_I   = (1 << (VALUE_W - 1)) - 1;
   localparam int VALUE_SPAN    = 1 << (VALUE_W - 1);
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;

   typedef sample_type frame_type [NUM_CH];

   typedef struct packed {
      req_kind_type kind;
      logic [1:0]   chan;
      sample_type   row;
   } request_type;

   typedef struct {
      quality_type           quality;
      logic [RUN_W-1:0]      run;
      logic [MASK_OUT_W-1:0] mask;
      logic                  usable;
      logic                  changing;
   } grade_type;

   logic                       clock;
   logic                       reset              = 1'b1;
   logic                       req_valid          = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_type           = REQ_CHANNEL;
   logic [1:0]                 req_channel_index  = '0;
   logic signed [VALUE_W-1:0]  req_delta_value    = '0;
   logic signed [VALUE_W-1:0]  req_raw_value      = '0;
   logic signed [VALUE_W-1:0]  req_baseline_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall          = 1'b0;
   logic [2:0]                 rsp_quality;
   logic [RUN_W-1:0]           rsp_identical_run;
   logic [MASK_OUT_W-1:0]      rsp_saturated_mask;
   logic                       rsp_data_usable;
   logic                       rsp_data_changing;
   logic                       csr_write_enable   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index          = CSR_TOLERANCE;
   logic [CSR_DATA_W-1:0]      csr_write_data     = '0;

   // predictor copy of the registers
   logic [TOL_W-1:0]    tol_cfg;
   logic [SAT_W-1:0]    sat_cfg;
   logic [THRESH_W-1:0] changes_cfg;
   logic [THRESH_W-1:0] sat_stuck_cfg;
   logic [THRESH_W-1:0] const_stuck_cfg;

   // predictor copy of the monitor state
   sample_type          prev_rows [NUM_CH];
   sample_type          pend_rows [NUM_CH];
   bit                  have_prev;
   bit                  sample_differs;
   logic [NUM_CH-1:0]   mask_acc;
   logic [NUM_CH-1:0]   mask_reg;
   int unsigned         ident_cnt;
   int unsigned         change_cnt;
   quality_type         grade_q;

   request_type         pending_requests [$];
   grade_type           expected_grades [$];
   logic [NUM_CH-1:0]   chan_seen    = '0;
   int                  queued_total = 0;
   int                  mismatches   = 0;
   int                  gap_left     = 0;
   int                  hold_left    = 0;
   int                  quiet_cycles = 0;
   bit                  quiet_tx     = 1'b0;
   bit                  quiet_rx     = 1'b0;

   sar_sample_health_monitor #(
      .CHANNELS   (NUM_CH),
      .COUNT_BITS (COUNT_W)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_channel_index  (req_channel_index),
      .req_delta_value    (req_delta_value),
      .req_raw_value      (req_raw_value),
      .req_baseline_value (req_baseline_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quality        (rsp_quality),
      .rsp_identical_run  (rsp_identical_run),
      .rsp_saturated_mask (rsp_saturated_mask),
      .rsp_data_usable    (rsp_data_usable),
      .rsp_data_changing  (rsp_data_changing),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit exceeds_tol(input logic signed [VALUE_W-1:0] a,
                                      input logic signed [VALUE_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) d = -d;
      return d > int'(tol_cfg);
   endfunction

   function automatic bit rows_differ(input sample_type a, input sample_type b);
      return exceeds_tol(a.delta, b.delta) || exceeds_tol(a.raw, b.raw) ||
             exceeds_tol(a.baseline, b.baseline);
   endfunction

   task automatic clear_monitor();
      int c;
      for (c = 0; c < NUM_CH; c++) begin
         prev_rows[c] = '0;
         pend_rows[c] = '0;
      end
      have_prev      = 1'b0;
      sample_differs = 1'b0;
      mask_acc       = '0;
      mask_reg       = '0;
      ident_cnt      = 0;
      change_cnt     = 0;
      grade_q        = QUAL_WARMING;
   endtask

   task automatic post_grade();
      grade_type g;
      g.quality  = grade_q;
      g.run      = (ident_cnt > RUN_MAX) ? RUN_MAX : RUN_W'(ident_cnt);
      g.mask     = MASK_OUT_W'(mask_reg);
      g.usable   = (grade_q == QUAL_VALID);
      g.changing = change_cnt > 0 && grade_q != QUAL_STUCK_CONST &&
                   grade_q != QUAL_STUCK_SAT && grade_q != QUAL_STALE;
      expected_grades.push_back(g);
   endtask

   task automatic grade_request(input req_kind_type kind, input logic [1:0] ch,
                                input sample_type row);
      int raw_i;
      int sat_i;
      if (kind == REQ_STALE) begin
         grade_q = QUAL_STALE;
         post_grade();
      end else if (kind == REQ_RESET) begin
         clear_monitor();
      end else if (kind == REQ_CHANNEL && ch < NUM_CH) begin
         if (rows_differ(prev_rows[ch], row)) sample_differs = 1'b1;
         pend_rows[ch] = row;
         raw_i = row.raw;
         sat_i = sat_cfg;
         if (raw_i >= sat_i) mask_acc[ch] = 1'b1;
         if (ch == LAST_CH) begin
            mask_reg = mask_acc;
            if (!have_prev) begin
               prev_rows = pend_rows;
               have_prev = 1'b1;
               grade_q   = QUAL_WARMING;
            end else begin
               if (!sample_differs) begin
                  if (ident_cnt < COUNT_MAX) ident_cnt++;
               end else begin
                  ident_cnt = 0;
                  if (change_cnt < COUNT_MAX) change_cnt++;
                  prev_rows = pend_rows;
               end
               if (mask_reg != 0)
                  grade_q = (ident_cnt >= sat_stuck_cfg) ? QUAL_STUCK_SAT : QUAL_SATURATED;
               else if (ident_cnt >= const_stuck_cfg)
                  grade_q = QUAL_STUCK_CONST;
               else if (change_cnt >= changes_cfg)
                  grade_q = QUAL_VALID;
               else
                  grade_q = QUAL_WARMING;
            end
            sample_differs = 1'b0;
            mask_acc       = '0;
            post_grade();
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [VALUE_W-1:0] any_value();
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic sample_type any_row();
      sample_type r;
      r.delta    = any_value();
      r.raw      = any_value();
      r.baseline = any_value();
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] high_raw();
      int s;
      s = sat_cfg;
      case ($urandom_range(0, 3))
         0:       return VALUE_W'(s);
         1:       return VALUE_MAX;
         default: return VALUE_W'(int'($urandom_range(s, VALUE_MAX_I)));
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] low_raw();
      int s;
      int r;
      s = sat_cfg;
      r = $urandom_range(0, 3);
      if (s == 0 || r == 0) return VALUE_W'(-int'($urandom_range(1, VALUE_SPAN)));
      if (r == 1) return VALUE_W'(s - 1);
      return VALUE_W'(int'($urandom_range(0, s - 1)));
   endfunction

   // steady: mostly held or moved within the tolerance; moving: frequent real changes
   function automatic logic signed [VALUE_W-1:0] drift(input logic signed [VALUE_W-1:0] v,
                                                       input bit moving);
      int t;
      int r;
      int j;
      t = tol_cfg;
      r = $urandom_range(0, moving ? 5 : 199);
      if (r == 0)
         j = ($urandom_range(0, 1) ? 1 : -1) * (t + 1 + int'($urandom_range(0, 3)));
      else if (moving && r == 1)
         return any_value();
      else if (r < (moving ? 4 : 50))
         j = int'($urandom_range(0, 2 * t)) - t;
      else
         j = 0;
      return VALUE_W'(int'(v) + j);
   endfunction

   // a last-channel request is only sent once every channel holds a value
   // written since the last clear
   task automatic queue_request(input req_kind_type kind, input logic [1:0] ch,
                                input sample_type row);
      request_type rq;
      int c;
      if (kind == REQ_CHANNEL && ch == LAST_CH) begin
         for (c = LAST_CH - 1; c >= 0; c--)
            if (!chan_seen[c]) ch = c[1:0];
      end
      if (kind == REQ_CHANNEL) chan_seen[ch] = 1'b1;
      else if (kind == REQ_RESET) chan_seen = '0;
      if (kind != REQ_NONE) queued_total++;
      rq.kind = kind;
      rq.chan = ch;
      rq.row  = row;
      pending_requests.push_back(rq);
   endtask

   task automatic queue_frame(input frame_type f, input bit ragged);
      int c;
      int r;
      for (c = 0; c < NUM_CH; c++) begin
         r = ragged ? $urandom_range(0, 59) : 2;
         if (r != 0 || c == LAST_CH) queue_request(REQ_CHANNEL, c[1:0], f[c]);
         if (r == 1) queue_request(REQ_CHANNEL, c[1:0], f[c]);
      end
   endtask

   task automatic add_scene();
      frame_type anchor;
      frame_type cur;
      int pick;
      int style;
      int hot;
      int reps;
      int c;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         queue_request(REQ_STALE, 2'($urandom), any_row());
      end else if (pick < 6) begin
         queue_request(REQ_RESET, 2'($urandom), any_row());
      end else if (pick < 9) begin
         queue_request(REQ_NONE, 2'($urandom), any_row());
      end else if (pick < 15) begin
         queue_request(REQ_CHANNEL, 2'($urandom), any_row());
      end else begin
         style = $urandom_range(0, 2);
         hot   = $urandom_range(0, LAST_CH);
         for (c = 0; c < NUM_CH; c++) begin
            anchor[c] = any_row();
            anchor[c].raw = (style == 2 && (c == hot || $urandom_range(0, 1))) ?
                            high_raw() : low_raw();
         end
         reps = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 36) : $urandom_range(1, 8);
         repeat (reps) begin
            for (c = 0; c < NUM_CH; c++) begin
               cur[c].delta    = drift(anchor[c].delta, style == 1);
               cur[c].raw      = drift(anchor[c].raw, style == 1);
               cur[c].baseline = drift(anchor[c].baseline, style == 1);
            end
            queue_frame(cur, 1'b1);
            for (c = 0; c < NUM_CH; c++)
               if (rows_differ(anchor[c], cur[c])) begin
                  anchor = cur;
                  break;
               end
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TOLERANCE:   tol_cfg         = TOL_W'(val);
         CSR_SAT_LEVEL:   sat_cfg         = SAT_W'(val);
         CSR_CHANGES:     changes_cfg     = THRESH_W'(val);
         CSR_SAT_STUCK:   sat_stuck_cfg   = THRESH_W'(val);
         CSR_CONST_STUCK: const_stuck_cfg = THRESH_W'(val);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_grades.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin
      request_type nxt;
      sample_type  seen;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            seen.delta    = req_delta_value;
            seen.raw      = req_raw_value;
            seen.baseline = req_baseline_value;
            grade_request(req_kind_type'(req_type), req_channel_index, seen);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req_valid          <= 1'b1;
               req_type           <= nxt.kind;
               req_channel_index  <= nxt.chan;
               req_delta_value    <= nxt.row.delta;
               req_raw_value      <= nxt.row.raw;
               req_baseline_value <= nxt.row.baseline;
               if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
               gap_left <= quiet_tx ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor

   always @(posedge clock) begin
      grade_type   want;
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_grades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb_top: unexpected response q=%0d run=%0d mask=%h at %0t",
                        rsp_quality, rsp_identical_run, rsp_saturated_mask, $time);
         end else begin
            want = expected_grades.pop_front();
            if (rsp_quality !== want.quality || rsp_identical_run !== want.run ||
                rsp_saturated_mask !== want.mask || rsp_data_usable !== want.usable ||
                rsp_data_changing !== want.changing) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tb_top: mismatch at %0t: expected q=%0d run=%0d mask=%h use=%0b",
                           $time, want.quality, want.run, want.mask, want.usable);
                  $display("tb_top:   expected chg=%0b, got q=%0d run=%0d mask=%h use=%0b chg=%0b",
                           want.changing, rsp_quality, rsp_identical_run,
                           rsp_saturated_mask, rsp_data_usable, rsp_data_changing);
               end
            end
         end
         if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
         n = quiet_rx ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
         hold_left <= n;
         rsp_stall <= (n != 0);
      end else if (rsp_valid && rsp_stall) begin
         if (hold_left <= 1) rsp_stall <= 1'b0;
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      frame_type a;
      frame_type b;
      int p;
      int start;
      tol_cfg         = TOL_RESET;
      sat_cfg         = SAT_LEVEL_RESET;
      changes_cfg     = CHANGES_RESET;
      sat_stuck_cfg   = SAT_STUCK_RESET;
      const_stuck_cfg = CONST_STUCK_RESET;
      clear_monitor();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, tolerance edge, stale, ignored type, repeat, reset
      a[0] = '{delta: VALUE_MIN, raw: VALUE_MAX, baseline: 20'sd0};
      a[1] = '{delta: VALUE_MAX, raw: VALUE_MIN, baseline: -20'sd1};
      a[2] = '{delta: 20'sd0, raw: 20'sd262135, baseline: VALUE_MAX};
      a[3] = '{delta: -20'sd1, raw: 20'sd262136, baseline: VALUE_MIN};
      queue_frame(a, 1'b0);
      a[2].delta = 20'sd1;        // exactly at the tolerance: still identical
      queue_frame(a, 1'b0);
      a[1].baseline = 20'sd1;     // one past the tolerance: a change
      queue_frame(a, 1'b0);
      queue_request(REQ_STALE, 2'd2, a[0]);
      queue_request(REQ_NONE, 2'd3, a[1]);
      for (p = 0; p < NUM_CH; p++)
         b[p] = '{delta: VALUE_W'(p * 7 - 9), raw: VALUE_W'(p * 1000 - 1500),
                  baseline: VALUE_W'(p)};
      queue_request(REQ_CHANNEL, 2'd0, b[0]);
      queue_request(REQ_CHANNEL, 2'd1, a[1]);
      queue_request(REQ_CHANNEL, 2'd1, b[1]);   // repeated channel overwrites
      queue_request(REQ_CHANNEL, 2'd2, b[2]);
      queue_request(REQ_CHANNEL, 2'd3, b[3]);
      queue_request(REQ_RESET, 2'd1, b[2]);
      queue_frame(b, 1'b0);
      wait_idle();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               write_csr(CSR_TOLERANCE, 0);
               write_csr(CSR_SAT_LEVEL, 0);
               write_csr(CSR_CHANGES, 0);
               write_csr(CSR_SAT_STUCK, 0);
               write_csr(CSR_CONST_STUCK, 0);
            end
            1: begin
               write_csr(CSR_TOLERANCE, (1 << TOL_W) - 1);
               write_csr(CSR_SAT_LEVEL, (1 << SAT_W) - 1);
               write_csr(CSR_CHANGES, (1 << THRESH_W) - 1);
               write_csr(CSR_SAT_STUCK, (1 << THRESH_W) - 1);
               write_csr(CSR_CONST_STUCK, (1 << THRESH_W) - 1);
            end
            default: begin
               write_csr(CSR_TOLERANCE, $urandom_range(0, 1) ? $urandom_range(0, 6) :
                                                               $urandom_range(0, 1023));
               write_csr(CSR_SAT_LEVEL, $urandom_range(0, (1 << SAT_W) - 1));
               write_csr(CSR_CHANGES, $urandom_range(0, 6));
               write_csr(CSR_SAT_STUCK, $urandom_range(0, 12));
               write_csr(CSR_CONST_STUCK, $urandom_range(0, 16));
            end
         endcase
         start = queued_total;
         while (queued_total - start < PHASE_ITEMS) add_scene();
         wait_idle();
      end

      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
